// ===== hdl/apcm_pkg.sv =====
// Shared types, constants and helpers for the adaptive palette color mapper.
package apcm_pkg;

  localparam int unsigned PALETTE_ENTRIES = 64;
  localparam int unsigned IDX_W           = 6;
  localparam int unsigned CNT_W           = 7;
  localparam int unsigned COLOR_W         = 16;
  localparam int unsigned DIST_W          = 13;
  localparam int unsigned QUEUE_DEPTH     = 2;
  localparam int unsigned QPTR_W          = 1;

  typedef enum logic [1:0] {
    HOW_EXACT   = 2'd0,
    HOW_ALLOC   = 2'd1,
    HOW_NEAREST = 2'd2
  } how_e;

  typedef struct packed {
    logic       func;
    logic [15:0] rgb565;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } in_t;

  typedef struct packed {
    logic [5:0]  color_index;
    how_e        how_found;
    logic        palette_write;
    logic [15:0] write_value;
  } out_t;

  // Head of the request queue as seen by the back end
  typedef struct packed {
    logic               valid;
    logic [COLOR_W-1:0] color;
  } qhead_t;

  // Truncate 8-bit channels to 5-6-5
  function automatic logic [COLOR_W-1:0] pack565(input logic [7:0] r,
                                                 input logic [7:0] g,
                                                 input logic [7:0] b);
    return {r[7:3], g[7:2], b[7:3]};
  endfunction

endpackage

// ===== hdl/adaptive_palette_color_mapper.sv =====
// The back end takes one request at a time: it walks all 64 palette entries through the single
//   registered read port of the palette RAM, one entry per cycle, before it takes the next.
// A two-entry request queue takes beats while the walk runs or a result waits to be taken.
// Reset: queue and output empty, entry 0 is black and used, next free entry is 1; the palette
//   RAM needs no clearing pass since no result uses an entry at or above the fill count.
module adaptive_palette_color_mapper (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  apcm_pkg::in_t    in_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output apcm_pkg::out_t   out_o
);

  apcm_pkg::qhead_t head;
  logic             pop;

  apcm_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_i       (in_i),
    .head_o     (head),
    .pop_i      (pop)
  );

  apcm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

endmodule

// ===== hdl/apcm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module apcm_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/apcm_front.sv =====
// Front end: accept request beats, pack the color, and queue it for the back end.
module apcm_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  apcm_pkg::in_t       in_i,
  output apcm_pkg::qhead_t    head_o,
  input  logic                pop_i
);

  logic [apcm_pkg::COLOR_W-1:0] fifo_q [apcm_pkg::QUEUE_DEPTH];
  logic [apcm_pkg::QPTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [apcm_pkg::QPTR_W:0]    count_q, count_d;
  logic [apcm_pkg::COLOR_W-1:0] color;
  logic                         push, pop;

  // Select the requested color form
  assign color = in_i.func ? apcm_pkg::pack565(in_i.red, in_i.green, in_i.blue)
                           : in_i.rgb565;

  assign in_ready_o   = (count_q != (apcm_pkg::QPTR_W + 1)'(apcm_pkg::QUEUE_DEPTH));
  assign push         = in_valid_i && in_ready_o;
  assign head_o.valid = (count_q != '0);
  assign head_o.color = fifo_q[rd_ptr_q];
  assign pop          = pop_i && head_o.valid;

  // Track occupancy
  always_comb begin
    case ({push, pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  // Advance pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      count_q <= count_d;
    end
  end

  // Store queued colors
  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= color;
    end
  end

endmodule

// ===== hdl/apcm_back.sv =====
// Back end: walk the palette for exact and nearest matches, allocate, and register the result.
module apcm_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  apcm_pkg::qhead_t  head_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output apcm_pkg::out_t    out_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_e;

  state_e                        state_q;
  logic [apcm_pkg::COLOR_W-1:0]  color_q;
  logic [apcm_pkg::CNT_W-1:0]    rd_cnt_q;
  logic                          cmp_vld_q;
  logic [apcm_pkg::IDX_W-1:0]    cmp_idx_q;
  logic                          hit_q;
  logic [apcm_pkg::IDX_W-1:0]    hit_idx_q;
  logic [apcm_pkg::IDX_W-1:0]    best_idx_q;
  logic [apcm_pkg::DIST_W-1:0]   best_dist_q;
  logic [apcm_pkg::CNT_W-1:0]    next_free_q;
  logic                          out_valid_q;
  apcm_pkg::out_t                out_q;

  logic [apcm_pkg::COLOR_W-1:0]  ram_rdata;
  logic [apcm_pkg::COLOR_W-1:0]  entry;
  logic signed [5:0]             dr, db;
  logic signed [6:0]             dg;
  logic signed [11:0]            dr_sq_full, db_sq_full;
  logic signed [13:0]            dg_sq_full;
  logic [apcm_pkg::DIST_W-1:0]   wdist;
  logic                          used, is_exact, is_better, last, full, alloc, commit;
  apcm_pkg::out_t                res;

  assign pop_o  = (state_q == S_IDLE) && head_i.valid;
  assign full   = (next_free_q == apcm_pkg::CNT_W'(apcm_pkg::PALETTE_ENTRIES));
  assign commit = (state_q == S_DONE) && (!out_valid_q || out_ready_i);
  assign alloc  = !hit_q && !full;

  apcm_ram #(
    .Width (apcm_pkg::COLOR_W),
    .Depth (apcm_pkg::PALETTE_ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (commit && alloc),
    .waddr_i (next_free_q[apcm_pkg::IDX_W-1:0]),
    .wdata_i (color_q),
    .raddr_i (rd_cnt_q[apcm_pkg::IDX_W-1:0]),
    .rdata_o (ram_rdata)
  );

  // Entry 0 is black and never reallocated; others are always written before use
  assign entry = (cmp_idx_q == '0) ? '0 : ram_rdata;

  // Weighted squared distance 2*dR^2 + dG^2 + 2*dB^2
  always_comb begin
    dr         = $signed({1'b0, entry[15:11]}) - $signed({1'b0, color_q[15:11]});
    dg         = $signed({1'b0, entry[10:5]})  - $signed({1'b0, color_q[10:5]});
    db         = $signed({1'b0, entry[4:0]})   - $signed({1'b0, color_q[4:0]});
    dr_sq_full = 12'(dr) * 12'(dr);
    dg_sq_full = 14'(dg) * 14'(dg);
    db_sq_full = 12'(db) * 12'(db);
    wdist      = apcm_pkg::DIST_W'({dr_sq_full[9:0], 1'b0})
               + apcm_pkg::DIST_W'(dg_sq_full[11:0])
               + apcm_pkg::DIST_W'({db_sq_full[9:0], 1'b0});
  end

  // Classify the entry under compare
  assign used      = ({1'b0, cmp_idx_q} < next_free_q);
  assign is_exact  = cmp_vld_q && used && (entry == color_q) && !hit_q;
  assign is_better = cmp_vld_q && (wdist < best_dist_q);
  assign last      = cmp_vld_q &&
                     (cmp_idx_q == apcm_pkg::IDX_W'(apcm_pkg::PALETTE_ENTRIES - 1));

  // Build the result beat
  always_comb begin
    res.palette_write = 1'b0;
    res.write_value   = '0;
    if (hit_q) begin
      res.color_index = hit_idx_q;
      res.how_found   = apcm_pkg::HOW_EXACT;
    end else if (!full) begin
      res.color_index   = next_free_q[apcm_pkg::IDX_W-1:0];
      res.how_found     = apcm_pkg::HOW_ALLOC;
      res.palette_write = 1'b1;
      res.write_value   = color_q;
    end else begin
      res.color_index = best_idx_q;
      res.how_found   = apcm_pkg::HOW_NEAREST;
    end
  end

  // Sequence one request: dequeue, walk all entries, commit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      color_q     <= '0;
      rd_cnt_q    <= '0;
      cmp_vld_q   <= 1'b0;
      cmp_idx_q   <= '0;
      hit_q       <= 1'b0;
      hit_idx_q   <= '0;
      best_idx_q  <= '0;
      best_dist_q <= '1;
      next_free_q <= apcm_pkg::CNT_W'(1);
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      cmp_vld_q <= (state_q == S_SCAN) &&
                   (rd_cnt_q < apcm_pkg::CNT_W'(apcm_pkg::PALETTE_ENTRIES));
      cmp_idx_q <= rd_cnt_q[apcm_pkg::IDX_W-1:0];
      if (out_valid_q && out_ready_i && !commit) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (head_i.valid) begin
            color_q     <= head_i.color;
            rd_cnt_q    <= '0;
            hit_q       <= 1'b0;
            best_idx_q  <= '0;
            best_dist_q <= '1;
            state_q     <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (rd_cnt_q < apcm_pkg::CNT_W'(apcm_pkg::PALETTE_ENTRIES)) begin
            rd_cnt_q <= rd_cnt_q + 1'b1;
          end
          if (is_exact) begin
            hit_q     <= 1'b1;
            hit_idx_q <= cmp_idx_q;
          end
          if (is_better) begin
            best_dist_q <= wdist;
            best_idx_q  <= cmp_idx_q;
          end
          if (last) begin
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (commit) begin
            out_valid_q <= 1'b1;
            out_q       <= res;
            if (alloc) begin
              next_free_q <= next_free_q + 1'b1;
            end
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

// ===== sim/tb.sv =====
// Testbench for the adaptive palette color mapper: directed and random requests against a palette model.
`timescale 1ns / 1ps

module tb;

  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned SETTLE_CYCLES  = 150;

  logic           clk       = 1'b0;
  logic           rst_n     = 1'b0;
  logic           in_valid  = 1'b0;
  logic           in_ready;
  apcm_pkg::in_t  in_beat   = '0;
  logic           out_valid;
  logic           out_ready = 1'b0;
  apcm_pkg::out_t out_beat;

  // Palette model: entry values, used marks and the next free slot
  logic [15:0] pal_color [apcm_pkg::PALETTE_ENTRIES];
  bit          pal_used  [apcm_pkg::PALETTE_ENTRIES];
  int unsigned pal_next;

  apcm_pkg::out_t expected_lookups [$];
  apcm_pkg::out_t want;
  int unsigned    mismatches   = 0;
  int unsigned    quiet_cycles = 0;
  int unsigned    ready_left   = 0;
  bit             no_idle      = 1'b0;

  adaptive_palette_color_mapper dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_i       (in_beat),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_o      (out_beat)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Mostly short idle stretches, now and then a long one
  function automatic int unsigned idle_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 80) begin
      return $urandom_range(1, 3);
    end else if (r < 96) begin
      return $urandom_range(4, 20);
    end
    return $urandom_range(40, 200);
  endfunction

  function automatic int color_distance(input logic [15:0] a, input logic [15:0] b);
    int dr;
    int dg;
    int db;
    dr = int'(a[15:11]) - int'(b[15:11]);
    dg = int'(a[10:5]) - int'(b[10:5]);
    db = int'(a[4:0]) - int'(b[4:0]);
    return 2 * dr * dr + dg * dg + 2 * db * db;
  endfunction

  // Map one request against the palette model and update it
  function automatic apcm_pkg::out_t lookup_color(input apcm_pkg::in_t req);
    logic [15:0]    c;
    apcm_pkg::out_t res;
    int             best_d;
    int             d;
    int unsigned    best_i;
    c = req.func ? {req.red[7:3], req.green[7:2], req.blue[7:3]} : req.rgb565;
    res = '0;
    for (int i = 0; i < apcm_pkg::PALETTE_ENTRIES; i++) begin
      if (pal_used[i] && pal_color[i] == c) begin
        res.color_index = 6'(i);
        res.how_found   = apcm_pkg::HOW_EXACT;
        return res;
      end
    end
    if (pal_next < apcm_pkg::PALETTE_ENTRIES) begin
      pal_color[pal_next] = c;
      pal_used[pal_next]  = 1'b1;
      res.color_index     = 6'(pal_next);
      res.how_found       = apcm_pkg::HOW_ALLOC;
      res.palette_write   = 1'b1;
      res.write_value     = c;
      pal_next++;
      return res;
    end
    best_d = 32'h7fffffff;
    best_i = 0;
    for (int i = 0; i < apcm_pkg::PALETTE_ENTRIES; i++) begin
      d = color_distance(pal_color[i], c);
      if (d < best_d) begin
        best_d = d;
        best_i = i;
      end
    end
    res.color_index = 6'(best_i);
    res.how_found   = apcm_pkg::HOW_NEAREST;
    return res;
  endfunction

  function automatic apcm_pkg::in_t make_565(input logic [15:0] v);
    apcm_pkg::in_t req;
    req.func   = 1'b0;
    req.rgb565 = v;
    req.red    = 8'($urandom);
    req.green  = 8'($urandom);
    req.blue   = 8'($urandom);
    return req;
  endfunction

  function automatic apcm_pkg::in_t make_bytes(input logic [7:0] r, input logic [7:0] g,
                                               input logic [7:0] b);
    apcm_pkg::in_t req;
    req.func   = 1'b1;
    req.rgb565 = 16'($urandom);
    req.red    = r;
    req.green  = g;
    req.blue   = b;
    return req;
  endfunction

  // Random request; with reuse set, pick a color already in the palette
  function automatic apcm_pkg::in_t random_request(input bit reuse);
    apcm_pkg::in_t req;
    logic [15:0]   c;
    req.func   = 1'($urandom_range(0, 1));
    req.rgb565 = 16'($urandom);
    req.red    = 8'($urandom);
    req.green  = 8'($urandom);
    req.blue   = 8'($urandom);
    if (reuse) begin
      c          = pal_color[$urandom_range(0, pal_next - 1)];
      req.rgb565 = c;
      req.red    = {c[15:11], req.red[2:0]};
      req.green  = {c[10:5], req.green[1:0]};
      req.blue   = {c[4:0], req.blue[2:0]};
    end
    return req;
  endfunction

  // Present one beat, hold it until accepted, then predict and sometimes idle
  task automatic send_item(input apcm_pkg::in_t req);
    int unsigned gap;
    @(negedge clk);
    in_valid <= 1'b1;
    in_beat  <= req;
    do @(posedge clk); while (!in_ready);
    expected_lookups.push_back(lookup_color(req));
    gap = (no_idle || $urandom_range(0, 1) == 0) ? 0 : idle_length();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Drop valid and hold off until every pending result has arrived
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_lookups.size() != 0) @(posedge clk);
  endtask

  task automatic test_black_and_grid();
    send_item(make_565(16'h0000));
    // low byte bits truncate away, still black
    send_item(make_bytes(8'h07, 8'h03, 8'h07));
    // grid values of unused entries must allocate, not match
    send_item(make_bytes(8'd85, 8'd85, 8'd85));
    send_item(make_565(16'h000A));
    send_item(make_565(16'hFFFF));
    send_item(make_bytes(8'hFF, 8'hFF, 8'hFF));
    send_item(make_565({5'd10, 6'd21, 5'd10}));
  endtask

  task automatic test_field_extremes();
    send_item(make_565(16'h8000));
    send_item(make_565(16'h0001));
    send_item(make_565(16'hF800));
    send_item(make_565(16'h07E0));
    send_item(make_565(16'h001F));
    send_item(make_565(16'hAAAA));
    send_item(make_565(16'h5555));
    send_item(make_bytes(8'h80, 8'h00, 8'h00));
    send_item(make_bytes(8'h00, 8'h80, 8'h00));
    send_item(make_bytes(8'h00, 8'h00, 8'h80));
    send_item(make_bytes(8'hF8, 8'hFC, 8'hF8));
    send_item(make_bytes(8'h7F, 8'h01, 8'hFE));
  endtask

  task automatic test_random_fill(input int unsigned count);
    repeat (count) send_item(random_request($urandom_range(0, 99) < 35));
    // make sure the palette is full before the nearest-search tests
    while (pal_next < apcm_pkg::PALETTE_ENTRIES) send_item(random_request(1'b0));
  endtask

  // Search for colors equally near two or more entries; lowest index must win
  task automatic test_nearest_ties();
    logic [15:0] probe;
    int          best;
    int          hits;
    int          d;
    int unsigned found;
    found = 0;
    for (int t = 0; t < 20000 && found < 8; t++) begin
      probe = 16'($urandom);
      best  = 32'h7fffffff;
      hits  = 0;
      for (int i = 0; i < apcm_pkg::PALETTE_ENTRIES; i++) begin
        d = color_distance(pal_color[i], probe);
        if (d < best) begin
          best = d;
          hits = 1;
        end else if (d == best) begin
          hits++;
        end
      end
      if (best > 0 && hits > 1) begin
        send_item(make_565(probe));
        found++;
      end
    end
  endtask

  task automatic test_random_mix(input int unsigned count);
    repeat (count) send_item(random_request($urandom_range(0, 99) < 35));
  endtask

  task automatic test_back_to_back(input int unsigned count);
    no_idle = 1'b1;
    repeat (count) send_item(random_request($urandom_range(0, 99) < 35));
    no_idle = 1'b0;
  endtask

  initial begin
    logic [7:0] lr;
    logic [7:0] lg;
    logic [7:0] lb;
    // Load the reset palette: 4x4x4 grid, only black marked used
    for (int i = 0; i < apcm_pkg::PALETTE_ENTRIES; i++) begin
      lr = 8'(((i >> 4) & 3) * 85);
      lg = 8'(((i >> 2) & 3) * 85);
      lb = 8'((i & 3) * 85);
      pal_color[i] = {lr[7:3], lg[7:2], lb[7:3]};
      pal_used[i]  = 1'b0;
    end
    pal_color[0] = '0;
    pal_used[0]  = 1'b1;
    pal_next     = 1;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_black_and_grid();
    test_field_extremes();
    wait_drained();
    test_random_fill(350);
    wait_drained();
    test_nearest_ties();
    test_random_mix(1100);
    test_back_to_back(200);

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("adaptive_palette_color_mapper regression: pass");
    end else begin
      $display("adaptive_palette_color_mapper regression: fail");
    end
    $finish;
  end

  // Toggle result ready with random hold and stall lengths
  always @(negedge clk) begin
    if (no_idle) begin
      out_ready <= 1'b1;
    end else if (ready_left > 0) begin
      ready_left = ready_left - 1;
    end else if ($urandom_range(0, 9) < 7) begin
      out_ready <= 1'b1;
      ready_left = $urandom_range(0, 30);
    end else begin
      out_ready <= 1'b0;
      ready_left = idle_length();
    end
  end

  // Compare each result beat with the oldest pending lookup
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_lookups.size() == 0) begin
        $error("result beat with nothing pending: color_index %0d", out_beat.color_index);
        mismatches++;
      end else begin
        want = expected_lookups.pop_front();
        if (out_beat.color_index !== want.color_index) begin
          $error("color_index: expected %0d, got %0d", want.color_index, out_beat.color_index);
          mismatches++;
        end
        if (out_beat.how_found !== want.how_found) begin
          $error("how_found: expected %0d, got %0d", want.how_found, out_beat.how_found);
          mismatches++;
        end
        if (out_beat.palette_write !== want.palette_write) begin
          $error("palette_write: expected %0d, got %0d", want.palette_write,
                 out_beat.palette_write);
          mismatches++;
        end
        if (out_beat.write_value !== want.write_value) begin
          $error("write_value: expected %h, got %h", want.write_value, out_beat.write_value);
          mismatches++;
        end
      end
    end
  end

  // End the run when no beat moves for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("adaptive_palette_color_mapper regression: fail");
        $finish;
      end
    end
  end

endmodule
